/* rtl/core/ptw_pkg.sv */
// Package for the four-level page-table engine.
// Holds sizes, flag masks, command codes and request/response types; no dependencies.
package ptw_pkg;

  localparam int unsigned MAX_TABLES = 16;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W = 9;
  localparam int unsigned SLOT_W = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int unsigned ADDR_W = SLOT_W + IDX_W;
  localparam int unsigned TBL_DEPTH = (1 << SLOT_W) * ENTRIES_PER_TABLE;
  localparam int unsigned TIU_W = $clog2(MAX_TABLES + 1);

  localparam logic [63:0] ADDR_MASK    = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] F_PRESENT    = 64'h1;
  localparam logic [63:0] F_WRITE      = 64'h2;
  localparam logic [63:0] F_USER       = 64'h4;
  localparam logic [63:0] F_ACCESSED   = 64'h20;
  localparam logic [63:0] F_DIRTY      = 64'h40;
  localparam logic [63:0] F_HUGE       = 64'h80;
  localparam logic [63:0] F_GLOBAL     = 64'h100;
  localparam logic [63:0] F_NX         = 64'h8000_0000_0000_0000;
  localparam logic [63:0] LEAF_ALLOWED = 64'h8000_0000_0000_011e;

  typedef enum logic [2:0] {
    CMD_MAP4K     = 3'd0,
    CMD_MAP2M     = 3'd1,
    CMD_UNMAP     = 3'd2,
    CMD_PROTECT   = 3'd3,
    CMD_TRANSLATE = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [47:0] virt_addr;
    logic [51:0] phys_addr;
    logic [63:0] flags;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [51:0] xlat_pa;
    logic [63:0] xlat_flags;
  } rsp_t;

endpackage

/* rtl/core/ptw_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ptw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/four_level_page_table_engine.sv */
// Top level of the four-level page-table engine: walk sequencer and table store.
// Depends on ptw_pkg and ptw_ram.
//
//  channel | direction | handshake                 | payload
//  request | in        | req_valid_i / req_ready_o | req_i (req_t)
//  result  | out       | rsp_valid_o / rsp_ready_i | rsp_o (rsp_t)
//
// One request at a time. The walk reads one table entry per cycle from the
// single-read-port table store, root level first; early rejects read no entry.
// After reset a clearing pass zeroes all TBL_DEPTH (8192) entries, one per
// cycle; no request is taken during it.
// A result waits in the output register; a new request is taken meanwhile,
// and its walk stalls in S_DONE until that register is free.
module four_level_page_table_engine
  import ptw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  state_e state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  req_t req_q, req_d;
  logic [1:0] lvl_q, lvl_d;
  logic [TIU_W-1:0] tiu_q, tiu_d;
  logic acc_w_q, acc_w_d, acc_u_q, acc_u_d, acc_nx_q, acc_nx_d;
  logic [ADDR_W-1:0] cur_q, cur_d;
  rsp_t res_q, res_d;
  rsp_t rsp_q, rsp_d;
  logic rsp_valid_q, rsp_valid_d;

  // table store port
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [63:0]       wdata, e;
  logic [63:0]       wdata_mux;
  logic              we_mux;

  ptw_ram #(
    .WIDTH(64),
    .DEPTH(TBL_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we_mux),
    .waddr_i(waddr),
    .wdata_i(wdata_mux),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(e)
  );

  // table index of a level; level 0 is the root (bits 47..39)
  function automatic logic [IDX_W-1:0] lvl_idx(logic [47:0] va, logic [1:0] lvl);
    logic [IDX_W-1:0] r;
    case (lvl)
      2'd0:    r = va[47:39];
      2'd1:    r = va[38:30];
      2'd2:    r = va[29:21];
      default: r = va[20:12];
    endcase
    return r;
  endfunction

  logic pres, huge, child_ok, full, flags_ok, pre_ok;
  logic fail, fin_ok, down;
  logic [SLOT_W-1:0] child_slot, dn_slot, fresh;
  logic w_all, u_all, nx_any;
  logic [51:0] pout;
  logic [63:0] fout, leaf_word, tbl_word;
  logic [1:0] leaf_lvl;
  cmd_e cmd;

  assign cmd        = cmd_e'(req_q.command);
  assign pres       = e[0];
  assign huge       = e[7];
  assign child_ok   = e[51:12] < 40'(MAX_TABLES);
  assign child_slot = e[12 +: SLOT_W];
  assign full       = tiu_q >= TIU_W'(MAX_TABLES);
  assign fresh      = tiu_q[SLOT_W-1:0];
  assign w_all      = acc_w_q & e[1];
  assign u_all      = acc_u_q & e[2];
  assign nx_any     = acc_nx_q | e[63];
  assign leaf_lvl   = (cmd == CMD_MAP2M) ? 2'd2 : 2'd3;
  assign leaf_word  = (({12'b0, req_q.phys_addr}) & ADDR_MASK) | req_q.flags | F_PRESENT |
                      ((cmd == CMD_MAP2M) ? F_HUGE : 64'h0);
  assign tbl_word   = ((64'(fresh) << 12) & ADDR_MASK) | F_PRESENT | F_WRITE |
                      (req_q.flags & F_USER);
  assign flags_ok   = (req_i.flags & ~LEAF_ALLOWED) == 64'h0;

  // checks made at accept, before any table read
  always_comb begin
    case (req_i.command)
      CMD_MAP4K:     pre_ok = (req_i.virt_addr[11:0] == '0) &&
                              (req_i.phys_addr[11:0] == '0) && flags_ok;
      CMD_MAP2M:     pre_ok = (req_i.virt_addr[20:0] == '0) &&
                              (req_i.phys_addr[20:0] == '0) && flags_ok;
      CMD_UNMAP:     pre_ok = (req_i.virt_addr[11:0] == '0);
      CMD_PROTECT:   pre_ok = (req_i.virt_addr[11:0] == '0) && flags_ok;
      CMD_TRANSLATE: pre_ok = 1'b1;
      default:       pre_ok = 1'b0;
    endcase
  end

  // decision on the entry just read
  always_comb begin
    fail    = 1'b0;
    fin_ok  = 1'b0;
    down    = 1'b0;
    dn_slot = child_slot;
    pout    = '0;
    fout    = '0;
    we      = 1'b0;
    wdata   = '0;
    tiu_d   = tiu_q;
    if (state_q == S_EVAL) begin
      case (cmd)
        CMD_TRANSLATE: begin
          if (!pres) begin
            fail = 1'b1;
          end else if (lvl_q == 2'd2 && huge) begin
            fin_ok = 1'b1;
            pout = (e[51:0] & ADDR_MASK[51:0]) + 52'(req_q.virt_addr[20:0]);
            fout = F_PRESENT | F_HUGE | (e & F_GLOBAL) |
                   (w_all ? F_WRITE : 64'h0) | (u_all ? F_USER : 64'h0) |
                   (nx_any ? F_NX : 64'h0);
          end else if (lvl_q == 2'd3) begin
            fin_ok = 1'b1;
            pout = (e[51:0] & ADDR_MASK[51:0]) + 52'(req_q.virt_addr[11:0]);
            fout = F_PRESENT | (e & (F_GLOBAL | F_DIRTY | F_ACCESSED)) |
                   (w_all ? F_WRITE : 64'h0) | (u_all ? F_USER : 64'h0) |
                   (nx_any ? F_NX : 64'h0);
          end else if (child_ok) begin
            down = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
        CMD_MAP4K, CMD_MAP2M: begin
          if (lvl_q == leaf_lvl) begin
            if (pres) begin
              fail = 1'b1;
            end else begin
              we = 1'b1;
              wdata = leaf_word;
              fin_ok = 1'b1;
            end
          end else if (cmd == CMD_MAP4K && lvl_q == 2'd2 && huge) begin
            fail = 1'b1;
          end else if (pres) begin
            if (child_ok) begin
              down = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end else if (full) begin
            fail = 1'b1;
          end else begin
            // missing table: take the next free slot (already zero)
            we = 1'b1;
            wdata = tbl_word;
            down = 1'b1;
            dn_slot = fresh;
            tiu_d = tiu_q + 1'b1;
          end
        end
        CMD_UNMAP, CMD_PROTECT: begin
          if (lvl_q == 2'd3) begin
            if (pres) begin
              we = 1'b1;
              wdata = (cmd == CMD_UNMAP) ? 64'h0 :
                      ((e & ADDR_MASK) | (req_q.flags & ~ADDR_MASK) | F_PRESENT);
              fin_ok = 1'b1;
            end else begin
              fail = 1'b1;
            end
          end else if (lvl_q == 2'd2 && huge) begin
            fail = 1'b1;
          end else if (pres && child_ok) begin
            down = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
        default: fail = 1'b1;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    req_d       = req_q;
    lvl_d       = lvl_q;
    acc_w_d     = acc_w_q;
    acc_u_d     = acc_u_q;
    acc_nx_d    = acc_nx_q;
    cur_d       = cur_q;
    res_d       = res_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    req_ready_o = 1'b0;
    re          = 1'b0;
    raddr       = {{SLOT_W{1'b0}}, req_i.virt_addr[47:39]};
    waddr       = cur_q;
    case (state_q)
      S_CLEAR: begin
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == ADDR_W'(TBL_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d    = req_i;
          lvl_d    = 2'd0;
          acc_w_d  = 1'b1;
          acc_u_d  = 1'b1;
          acc_nx_d = 1'b0;
          cur_d    = raddr;
          if (pre_ok) begin
            re      = 1'b1;
            state_d = S_EVAL;
          end else begin
            res_d   = '0;
            state_d = S_DONE;
          end
        end
      end
      S_EVAL: begin
        if (down) begin
          raddr    = {dn_slot, lvl_idx(req_q.virt_addr, lvl_q + 2'd1)};
          re       = 1'b1;
          cur_d    = raddr;
          lvl_d    = lvl_q + 2'd1;
          acc_w_d  = w_all;
          acc_u_d  = u_all;
          acc_nx_d = nx_any;
        end else begin
          res_d.ok         = fin_ok && !fail;
          res_d.xlat_pa    = pout;
          res_d.xlat_flags = fout;
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_d       = res_q;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // clearing pass writes zeros
  assign we_mux    = (state_q == S_CLEAR) || we;
  assign wdata_mux = (state_q == S_CLEAR) ? 64'h0 : wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      tiu_q       <= TIU_W'(1);
      rsp_valid_q <= 1'b0;
      lvl_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      tiu_q       <= tiu_d;
      rsp_valid_q <= rsp_valid_d;
      lvl_q       <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    acc_w_q  <= acc_w_d;
    acc_u_q  <= acc_u_d;
    acc_nx_q <= acc_nx_d;
    cur_q    <= cur_d;
    res_q    <= res_d;
    rsp_q    <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
